// File: sv/ucer_pkg.sv
// ----------------------------------------------------------------------------
// ucer_pkg
// Types, codes and descriptor ROM for the endpoint-zero responder.
// ----------------------------------------------------------------------------
`default_nettype none
package ucer_pkg;

  localparam int MAX_PACKET = 64;
  localparam int ROM_AW     = 8;
  localparam int ROM_DEPTH  = 164;

  typedef enum logic [1:0] {
    FN_SETUP = 2'd0, FN_OUT = 2'd1, FN_IN_DONE = 2'd2, FN_BUS_RESET = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    K_NONE = 2'd0, K_DATA = 2'd1, K_ZLP = 2'd2, K_STALL = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    SRC_NONE = 4'd0, SRC_DEV = 4'd1, SRC_CFG = 4'd2, SRC_LANG = 4'd3,
    SRC_MANUF = 4'd4, SRC_PROD = 4'd5, SRC_SERIAL = 4'd6, SRC_CFGVAL = 4'd7,
    SRC_STATUS = 4'd8, SRC_LINE = 4'd9
  } src_t;

  // Responder control states.
  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_DECODE, ST_FETCH, ST_EMIT} st_t;

  localparam logic [7:0] REQ_GET_STATUS  = 8'h00;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG  = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] REQ_SET_LINE    = 8'h20;
  localparam logic [7:0] REQ_GET_LINE    = 8'h21;
  localparam logic [7:0] REQ_SET_CTRL    = 8'h22;
  localparam logic [1:0] TYPE_STD        = 2'd0;
  localparam logic [1:0] TYPE_CLASS      = 2'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
    logic [6:0] device_address;
    logic       configured;
    logic       port_open;
  } out_item_t;

  // State record held in the context memory.
  typedef struct packed {
    logic [6:0] pending_address;
    logic [6:0] applied_address;
    logic       configured_flag;
    logic       dtr_flag;
    logic       config_snapshot;
    logic [7:0] remaining_bytes;
    logic [3:0] reply_source;
    logic [7:0] reply_offset;
  } ctx_t;

  // Base of each source in the flat ROM, and its size.
  function automatic logic [ROM_AW-1:0] src_base(input logic [3:0] s);
    unique case (s)
      SRC_DEV:    src_base = 8'd0;
      SRC_CFG:    src_base = 8'd18;
      SRC_LANG:   src_base = 8'd85;
      SRC_MANUF:  src_base = 8'd89;
      SRC_PROD:   src_base = 8'd111;
      SRC_SERIAL: src_base = 8'd139;
      SRC_LINE:   src_base = 8'd157;
      default:    src_base = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] src_len(input logic [3:0] s);
    unique case (s)
      SRC_DEV:    src_len = 8'd18;
      SRC_CFG:    src_len = 8'd67;
      SRC_LANG:   src_len = 8'd4;
      SRC_MANUF:  src_len = 8'd22;
      SRC_PROD:   src_len = 8'd28;
      SRC_SERIAL: src_len = 8'd18;
      SRC_LINE:   src_len = 8'd7;
      default:    src_len = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] rom_byte(input logic [ROM_AW-1:0] a);
    logic [7:0] t [ROM_DEPTH] = '{
      // device
      8'd18, 8'h01, 8'h00, 8'h02, 8'h02, 8'h00, 8'h00, 8'(MAX_PACKET),
      8'h83, 8'h04, 8'h40, 8'h57, 8'h00, 8'h02, 8'd1, 8'd2, 8'd3, 8'd1,
      // configuration
      8'd9, 8'h02, 8'd67, 8'h00, 8'd2, 8'd1, 8'd0, 8'h80, 8'd250,
      8'd9, 8'h04, 8'd0, 8'd0, 8'd1, 8'h02, 8'h02, 8'h01, 8'd0,
      8'd5, 8'h24, 8'h00, 8'h10, 8'h01,
      8'd5, 8'h24, 8'h01, 8'h00, 8'd1,
      8'd4, 8'h24, 8'h02, 8'h02,
      8'd5, 8'h24, 8'h06, 8'd0, 8'd1,
      8'd7, 8'h05, 8'h83, 8'h03, 8'd8, 8'h00, 8'hFF,
      8'd9, 8'h04, 8'd1, 8'd0, 8'd2, 8'h0A, 8'h00, 8'h00, 8'd0,
      8'd7, 8'h05, 8'h02, 8'h02, 8'd64, 8'h00, 8'd0,
      8'd7, 8'h05, 8'h81, 8'h02, 8'd64, 8'h00, 8'd0,
      // language
      8'd4, 8'h03, 8'h09, 8'h04,
      // manufacturer
      8'd22, 8'h03, 8'h53, 8'd0, 8'h63, 8'd0, 8'h6F, 8'd0, 8'h75, 8'd0, 8'h74, 8'd0,
      8'h32, 8'd0, 8'h4D, 8'd0, 8'h61, 8'd0, 8'h70, 8'd0, 8'h20, 8'd0,
      // product
      8'd28, 8'h03, 8'h44, 8'd0, 8'h72, 8'd0, 8'h69, 8'd0, 8'h76, 8'd0, 8'h65, 8'd0,
      8'h20, 8'd0, 8'h43, 8'd0, 8'h6F, 8'd0, 8'h6E, 8'd0, 8'h74, 8'd0, 8'h72, 8'd0,
      8'h6F, 8'd0, 8'h6C, 8'd0,
      // serial
      8'd18, 8'h03, 8'h53, 8'd0, 8'h32, 8'd0, 8'h4D, 8'd0, 8'h2D, 8'd0, 8'h44, 8'd0,
      8'h52, 8'd0, 8'h56, 8'd0, 8'h31, 8'd0,
      // line coding
      8'h00, 8'hC2, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08
    };
    rom_byte = (a < ROM_AW'(ROM_DEPTH)) ? t[a] : 8'h00;
  endfunction

endpackage
`default_nettype wire

// File: sv/ucer_ctx_mem.sv
// ----------------------------------------------------------------------------
// ucer_ctx_mem
// One-entry context memory with synchronous read.
// ----------------------------------------------------------------------------
`default_nettype none
module ucer_ctx_mem
  import ucer_pkg::*;
(
  input  wire logic clk,
  input  wire logic we,
  input  wire ctx_t wdata,
  output ctx_t      rdata
);
  ctx_t mem [1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[0] <= wdata;
    end
    rdata <= we ? wdata : mem[0];
  end
endmodule
`default_nettype wire

// File: sv/ucer_rom.sv
// ----------------------------------------------------------------------------
// ucer_rom
// Descriptor and line-coding ROM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ucer_rom
  import ucer_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [ROM_AW-1:0] addr,
  output logic [7:0]             data
);
  always_ff @(posedge clk) begin
    data <= rom_byte(addr);
  end
endmodule
`default_nettype wire

// File: sv/usb_control_endpoint_responder.sv
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder
// Endpoint-zero responder: standard and CDC requests, chunked replies.
// ----------------------------------------------------------------------------
//  channel | direction | payload    | handshake
//  in_     | input     | in_item_t  | in_valid / in_ready
//  out_    | output    | out_item_t | out_valid / out_ready
//
// After accept an item passes through the context-read and decode states. A
// data reply then takes a ROM read and then an emit for each byte; a single
// non-data item takes one emit. in_ready returns the cycle after the last emit.
// Reset is synchronous; the context record is written to zero while in_ready
// is held low. A stalled output holds the result register and the emit state.
// ----------------------------------------------------------------------------
`default_nettype none
module usb_control_endpoint_responder
  import ucer_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);
  st_t        st_r, st_nxt;
  in_item_t   item_r;
  ctx_t       ctx_rd, ctx_w;
  logic       ctx_we;
  logic       init_r;
  ctx_t       live_r, live_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [6:0] cnt_r, cnt_nxt;      // bytes left in this chunk
  logic [7:0] off_r, off_nxt;      // ROM offset of next byte
  logic [3:0] src_r, src_nxt;
  logic       ov_r, ov_nxt;
  out_item_t  ob_r, ob_nxt;
  logic [ROM_AW-1:0] rom_a;
  logic [7:0] rom_d;

  ucer_ctx_mem u_mem (.clk(clk), .we(ctx_we), .wdata(ctx_w), .rdata(ctx_rd));
  ucer_rom     u_rom (.clk(clk), .addr(rom_a), .data(rom_d));

  assign in_ready  = (st_r == ST_IDLE) && init_r;
  assign out_valid = ov_r;
  assign out_data  = ob_r;
  assign rom_a     = src_base(src_r) + off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      init_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      init_r <= 1'b1;
      ov_r   <= ov_nxt;
    end
    if (in_valid && in_ready) item_r <= in_data;
    live_r <= live_nxt;
    kind_r <= kind_nxt;
    cnt_r  <= cnt_nxt;
    off_r  <= off_nxt;
    src_r  <= src_nxt;
    ob_r   <= ob_nxt;
  end

  function automatic logic [7:0] virt_byte(ctx_t c, logic [3:0] s, logic [7:0] r);
    unique case (s)
      SRC_CFGVAL: virt_byte = (c.reply_offset == 8'd0) ? {7'd0, c.config_snapshot} : 8'd0;
      SRC_STATUS: virt_byte = 8'd0;
      default:    virt_byte = r;
    endcase
  endfunction

  always_comb begin
    ctx_t c;
    logic [7:0] len;
    logic [7:0] chunk;
    logic       reply;
    logic       stall;
    logic [3:0] s;
    logic [7:0] fetched;
    st_nxt   = st_r;
    live_nxt = live_r;
    kind_nxt = kind_r;
    cnt_nxt  = cnt_r;
    off_nxt  = off_r;
    src_nxt  = src_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    ctx_we   = 1'b0;
    ctx_w    = ctx_rd;
    c        = ctx_rd;
    len      = 8'd0;
    chunk    = 8'd0;
    reply    = 1'b0;
    stall    = 1'b0;
    s        = SRC_NONE;
    fetched  = 8'd0;
    if (!init_r) begin
      ctx_we = 1'b1;
      ctx_w  = '0;
    end
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE:  if (in_valid && in_ready) st_nxt = ST_READ;
      ST_READ:  st_nxt = ST_DECODE;
      ST_DECODE: begin
        kind_nxt = K_NONE;
        unique case (func_t'(item_r.func))
          FN_SETUP: begin
            c.remaining_bytes = 8'd0;
            c.reply_source    = SRC_NONE;
            c.reply_offset    = 8'd0;
            kind_nxt          = K_ZLP;
            if (item_r.request_type[6:5] == TYPE_STD) begin
              priority case (item_r.request_code)
                REQ_SET_ADDRESS: c.pending_address = item_r.request_value[6:0];
                REQ_GET_DESC: begin
                  priority case (item_r.request_value[15:8])
                    8'h01: s = SRC_DEV;
                    8'h02: s = SRC_CFG;
                    8'h03: begin
                      priority case (item_r.request_value[7:0])
                        8'd0: s = SRC_LANG;
                        8'd1: s = SRC_MANUF;
                        8'd2: s = SRC_PROD;
                        8'd3: s = SRC_SERIAL;
                        default: s = SRC_NONE;
                      endcase
                    end
                    default: s = SRC_NONE;
                  endcase
                  if (s == SRC_NONE) stall = 1'b1;
                  else begin
                    reply = 1'b1;
                    len = src_len(s);
                    if (item_r.request_length < {8'd0, len}) len = item_r.request_length[7:0];
                  end
                end
                REQ_SET_CONFIG: c.configured_flag = (item_r.request_value != 16'd0);
                REQ_GET_CONFIG: begin
                  c.config_snapshot = ctx_rd.configured_flag;
                  s = SRC_CFGVAL; len = 8'd1; reply = 1'b1;
                end
                REQ_GET_STATUS: begin
                  s = SRC_STATUS; len = 8'd2; reply = 1'b1;
                end
                default: stall = 1'b1;
              endcase
            end else if (item_r.request_type[6:5] == TYPE_CLASS) begin
              priority case (item_r.request_code)
                REQ_SET_LINE: ;
                REQ_GET_LINE: begin
                  s = SRC_LINE; len = 8'd7; reply = 1'b1;
                end
                REQ_SET_CTRL: c.dtr_flag = item_r.request_value[0];
                default: stall = 1'b1;
              endcase
            end else begin
              stall = 1'b1;
            end
            if (stall) begin
              c = ctx_rd;
              c.remaining_bytes = 8'd0;
              c.reply_source    = SRC_NONE;
              c.reply_offset    = 8'd0;
              kind_nxt = K_STALL;
            end
            if (reply) begin
              c.reply_source    = s;
              c.reply_offset    = 8'd0;
              c.remaining_bytes = len;
            end
          end
          FN_OUT: begin
            c.remaining_bytes = 8'd0;
            c.reply_source    = SRC_NONE;
            c.reply_offset    = 8'd0;
            kind_nxt = K_ZLP;
          end
          FN_IN_DONE: begin
            if (c.pending_address != 7'd0) begin
              c.applied_address = c.pending_address;
              c.pending_address = 7'd0;
            end
            if (c.remaining_bytes != 8'd0 && c.reply_source != SRC_NONE) reply = 1'b1;
          end
          default: begin
            c.configured_flag = 1'b0;
            c.applied_address = 7'd0;
            c.pending_address = 7'd0;
            c.remaining_bytes = 8'd0;
            c.reply_source    = SRC_NONE;
            c.reply_offset    = 8'd0;
          end
        endcase
        if (reply) begin
          chunk = (c.remaining_bytes > 8'(MAX_PACKET)) ? 8'(MAX_PACKET) : c.remaining_bytes;
          src_nxt = c.reply_source;
          off_nxt = c.reply_offset;
          cnt_nxt = chunk[6:0];
          kind_nxt = (chunk == 8'd0) ? K_ZLP : K_DATA;
        end
        live_nxt = c;  // snapshot before chunk advance, used for emit
        ctx_w = c;
        if (reply) begin
          ctx_w.remaining_bytes = c.remaining_bytes - chunk;
          ctx_w.reply_offset    = c.reply_offset + chunk;
          if (ctx_w.remaining_bytes == 8'd0) ctx_w.reply_source = SRC_NONE;
        end
        ctx_we = 1'b1;
        st_nxt = (kind_nxt == K_DATA) ? ST_FETCH : ST_EMIT;
      end
      ST_FETCH: st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          ob_nxt.kind = kind_r;
          ob_nxt.device_address = live_r.applied_address;
          ob_nxt.configured = live_r.configured_flag;
          ob_nxt.port_open = live_r.configured_flag & live_r.dtr_flag;
          if (kind_r == K_DATA) begin
            fetched = virt_byte(live_r, src_r, rom_d);
            ob_nxt.data_byte = fetched;
            ob_nxt.last = (cnt_r == 7'd1);
            live_nxt.reply_offset = live_r.reply_offset + 8'd1;
            off_nxt = off_r + 8'd1;
            cnt_nxt = cnt_r - 7'd1;
            st_nxt = (cnt_r == 7'd1) ? ST_IDLE : ST_FETCH;
          end else begin
            ob_nxt.data_byte = 8'd0;
            ob_nxt.last = 1'b1;
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: sv/ucer_checker.sv
// ----------------------------------------------------------------------------
// ucer_checker
// Port-level checks for the endpoint-zero responder.
// ----------------------------------------------------------------------------
`default_nettype none
module ucer_checker
  import ucer_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != K_DATA |-> out_data.data_byte == 8'd0 && out_data.last)
    else $error("non-data item malformed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");

  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.port_open |-> out_data.configured)
    else $error("port open without configuration");
endmodule

bind usb_control_endpoint_responder ucer_checker u_chk (.*);
`default_nettype wire
